@@ rtl/core/sorted_key_item_list_macros.svh @@
// Assertion macros shared by the sorted key/item list RTL.
// Users must have clk and rst_n in scope at the point of use.
`ifndef SORTED_KEY_ITEM_LIST_MACROS_SVH
`define SORTED_KEY_ITEM_LIST_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define SKL_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define SKL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/skl_pkg.sv @@
// Shared types and constants for the sorted key/item list.
// No dependencies; imported by the controller, datapath and top level.
package skl_pkg;

    // List geometry.
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;

    // Key range limits used for saturation.
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PREPEND    = 3'd0,
        CMD_APPEND     = 3'd1,
        CMD_POP_FIRST  = 3'd2,
        CMD_INSERT     = 3'd3,
        CMD_REMOVE_KEY = 3'd4
    } cmd_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } ctl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic stop;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/core/sorted_key_item_list.sv @@
// Sorted key/item list: one command in, one result out per transfer.
// Prepend, append and remove-first commit without a walk; sorted insert and
// remove-by-key walk the list one entry per cycle until the search stops, and
// the result side can hold the commit. One command is in flight at a time, so
// a new command is taken only after the last one has committed its result.
// Reset: asynchronous, active low; the list is empty, entry contents undefined.
`include "sorted_key_item_list_macros.svh"

module sorted_key_item_list import skl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CMD_W-1:0]        command,
    input  logic [ITEM_W-1:0]       item,
    input  logic signed [KEY_W-1:0] key,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [ITEM_W-1:0]       out_item,
    output logic signed [KEY_W-1:0] out_key,
    output logic                    list_empty,
    output logic [CNT_W-1:0]        entry_count
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Sequencer.
    skl_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Storage, search and result register.
    skl_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .item        (item),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_item    (out_item),
        .out_key     (out_key),
        .list_empty  (list_empty),
        .entry_count (entry_count)
    );

    // A result is only committed once the walk has stopped and the slot is free.
    `SKL_ASSERT_NOW(a_commit_ok, ctl.commit, stat.stop && stat.out_free, "commit while busy")
    // An accepted command blocks the input in the following cycle.
    `SKL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second command taken")
    // The empty flag agrees with the reported count.
    `SKL_ASSERT_NOW(a_empty_count, out_valid, list_empty == (entry_count == '0), "empty flag")
    // The count never exceeds the list capacity.
    `SKL_ASSERT_NOW(a_count_cap, out_valid, entry_count <= CNT_W'(CAPACITY), "count overflow")

endmodule

@@ rtl/core/skl_controller.sv @@
// Sequencer for the sorted key/item list: accept, search walk, commit.
// Depends on skl_pkg for the state and command/status types.
module skl_controller import skl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.stop)
                begin
                    // Hold here until the output register can take the result.
                    if (stat.out_free)
                    begin
                        ctl.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/skl_datapath.sv @@
// Entry storage, search index, update logic and output register of the list.
// Depends on skl_pkg; driven by skl_controller through dp_cmd_t.
module skl_datapath import skl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    ctl,
    output dp_stat_t                   stat,
    input  logic [CMD_W-1:0]           command,
    input  logic [ITEM_W-1:0]          item,
    input  logic signed [KEY_W-1:0]    key,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [ITEM_W-1:0]          out_item,
    output logic signed [KEY_W-1:0]    out_key,
    output logic                       list_empty,
    output logic [CNT_W-1:0]           entry_count
);

    // Stored entries: a row of cells that shift toward or away from the head.
    logic signed [KEY_W-1:0] entry_keys_reg  [CAPACITY];
    logic [ITEM_W-1:0]       entry_items_reg [CAPACITY];

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        idx_next;
    cmd_t                    cmd_reg;
    logic [ITEM_W-1:0]       item_reg;
    logic signed [KEY_W-1:0] key_reg;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [ITEM_W-1:0]       out_item_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic                    list_empty_reg;
    logic [CNT_W-1:0]        entry_count_reg;

    logic signed [KEY_W-1:0] rd_key;
    logic [ITEM_W-1:0]       rd_item;
    logic signed [KEY_W-1:0] dec_key;
    logic signed [KEY_W-1:0] inc_key;
    logic                    full;
    logic                    empty;
    logic                    at_end;

    logic                    do_ins;
    logic                    do_del;
    logic [CNT_W-1:0]        pos;
    logic signed [KEY_W-1:0] new_key;
    logic [STATUS_W-1:0]     res_status;
    logic [ITEM_W-1:0]       res_item;
    logic signed [KEY_W-1:0] res_key;

    // Single read port into the entry row, addressed by the walk index.
    assign rd_key  = entry_keys_reg[idx_reg[IDX_W-1:0]];
    assign rd_item = entry_items_reg[idx_reg[IDX_W-1:0]];

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign at_end = (idx_reg == count_reg);

    // Saturating neighbor keys for prepend and append.
    assign dec_key = (rd_key == KEY_MIN) ? KEY_MIN : rd_key - KEY_W'(1);
    assign inc_key = (rd_key == KEY_MAX) ? KEY_MAX : rd_key + KEY_W'(1);

    // The walk stops at the insert point, at the matching key, at the list end or, for insert, when full.
    // The output register is free when it is empty or draining.
    always_comb
    begin
        stat.out_free = !out_valid_reg || !out_stall;
        case (cmd_reg)
            CMD_INSERT:     stat.stop = full || at_end || (rd_key >= key_reg);
            CMD_REMOVE_KEY: stat.stop = at_end || (rd_key == key_reg);
            default:        stat.stop = 1'b1;
        endcase
    end

    // Walk index: append starts at the tail, everything else at the head.
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.load)
        begin
            if ((cmd_t'(command) == CMD_APPEND) && (count_reg != '0))
            begin
                idx_next = count_reg - 1'b1;
            end
            else
            begin
                idx_next = '0;
            end
        end
        else if (ctl.step)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Result and update decision for the command in flight.
    always_comb
    begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        pos        = '0;
        new_key    = '0;
        res_status = ST_DONE;
        res_item   = '0;
        res_key    = '0;
        case (cmd_reg)
            CMD_PREPEND:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins  = 1'b1;
                    new_key = empty ? '0 : dec_key;
                    res_key = new_key;
                end
            end
            CMD_APPEND:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins  = 1'b1;
                    pos     = count_reg;
                    new_key = empty ? '0 : inc_key;
                    res_key = new_key;
                end
            end
            CMD_POP_FIRST:
            begin
                if (empty)
                begin
                    res_status = ST_MISS;
                end
                else
                begin
                    do_del   = 1'b1;
                    res_key  = rd_key;
                    res_item = rd_item;
                end
            end
            CMD_INSERT:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins  = 1'b1;
                    pos     = idx_reg;
                    new_key = key_reg;
                    res_key = key_reg;
                end
            end
            CMD_REMOVE_KEY:
            begin
                if (at_end)
                begin
                    res_status = ST_MISS;
                end
                else
                begin
                    do_del   = 1'b1;
                    pos      = idx_reg;
                    res_key  = key_reg;
                    res_item = rd_item;
                end
            end
            default:
            begin
                res_status = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.commit && do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.commit && do_del)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            cmd_reg       <= CMD_PREPEND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (ctl.load)
            begin
                cmd_reg <= cmd_t'(command);
            end
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Captured request and result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= item;
            key_reg  <= key;
        end
        if (ctl.commit)
        begin
            status_reg      <= res_status;
            out_item_reg    <= res_item;
            out_key_reg     <= res_key;
            list_empty_reg  <= (count_next == '0);
            entry_count_reg <= count_next;
        end
    end

    // Entry cells: each takes the new entry, its lower or its upper neighbor.
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        localparam logic [CNT_W-1:0] CellIdx = CNT_W'(j);

        always_ff @(posedge clk)
        begin
            if (ctl.commit && do_ins)
            begin
                if (CellIdx == pos)
                begin
                    entry_keys_reg[j]  <= new_key;
                    entry_items_reg[j] <= item_reg;
                end
                else if (CellIdx > pos)
                begin
                    if (j > 0)
                    begin
                        entry_keys_reg[j]  <= entry_keys_reg[(j > 0) ? j - 1 : 0];
                        entry_items_reg[j] <= entry_items_reg[(j > 0) ? j - 1 : 0];
                    end
                end
            end
            else if (ctl.commit && do_del)
            begin
                if ((CellIdx >= pos) && (j < CAPACITY - 1))
                begin
                    entry_keys_reg[j]  <= entry_keys_reg[(j < CAPACITY - 1) ? j + 1 : j];
                    entry_items_reg[j] <= entry_items_reg[(j < CAPACITY - 1) ? j + 1 : j];
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_item    = out_item_reg;
    assign out_key     = out_key_reg;
    assign list_empty  = list_empty_reg;
    assign entry_count = entry_count_reg;

endmodule
